>>> sv/b2d_pkg.sv
`timescale 1ns / 1ps
// shared widths, character codes and state type of the binary to decimal text converter
package b2d_pkg;

	localparam int IN_VALUE_W = 64;
	localparam int CHAR_W     = 6;
	localparam int DIGIT_W    = 4;

	localparam logic [CHAR_W-1:0] CHAR_MINUS = 6'd45;
	localparam logic [CHAR_W-1:0] CHAR_ZERO  = 6'd48;
	localparam logic [CHAR_W-1:0] CHAR_NINE  = 6'd57;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SKIP,
		ST_SIGN,
		ST_EMIT
	} emit_state_t;

endpackage

>>> sv/b2d_in_if.sv
`timescale 1ns / 1ps
// input channel: one binary word and its signed flag
interface b2d_in_if
	import b2d_pkg::*;
();
	logic                  valid;
	logic                  ready;
	logic [IN_VALUE_W-1:0] value;
	logic                  is_signed;

	modport source (output valid, output value, output is_signed, input ready);
	modport sink (input valid, input value, input is_signed, output ready);
endinterface

>>> sv/b2d_out_if.sv
`timescale 1ns / 1ps
// output channel: one text character and its end marker
interface b2d_out_if
	import b2d_pkg::*;
();
	logic              valid;
	logic              ready;
	logic [CHAR_W-1:0] ascii_char;
	logic              last;

	modport source (output valid, output ascii_char, output last, input ready);
	modport sink (input valid, input ascii_char, input last, output ready);
endinterface

>>> sv/b2d_dabble.sv
`timescale 1ns / 1ps
// bit-serial shift-and-add-3 conversion of a magnitude to packed bcd
module b2d_dabble
	import b2d_pkg::*;
#(
	parameter int VALUE_WIDTH = 64,
	parameter int MAX_DIGITS  = 20
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	input  logic [VALUE_WIDTH-1:0]          mag,
	input  logic                            neg,
	input  logic                            take,
	output logic                            busy,
	output logic                            res_valid,
	output logic [DIGIT_W*MAX_DIGITS-1:0]   bcd,
	output logic                            res_neg
);
	localparam int BCD_W = DIGIT_W * MAX_DIGITS;
	localparam int CNT_W = $clog2(VALUE_WIDTH + 1);

	logic [VALUE_WIDTH-1:0] mag_q;
	logic [BCD_W-1:0]       bcd_q;
	logic [BCD_W-1:0]       adj;
	logic [CNT_W-1:0]       cnt_q;
	logic                   conv_q;
	logic                   full_q;
	logic                   neg_q;

	// digits of five or more get three added before the doubling shift
	always_comb begin
		for (int i = 0; i < MAX_DIGITS; i++) begin
			adj[DIGIT_W*i +: DIGIT_W] = (bcd_q[DIGIT_W*i +: DIGIT_W] >= 4'd5) ?
				bcd_q[DIGIT_W*i +: DIGIT_W] + 4'd3 : bcd_q[DIGIT_W*i +: DIGIT_W];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			conv_q <= 1'b0;
			full_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			conv_q <= 1'b1;
			cnt_q  <= CNT_W'(VALUE_WIDTH);
		end else if (conv_q) begin
			cnt_q <= cnt_q - CNT_W'(1);
			if (cnt_q == CNT_W'(1)) begin
				conv_q <= 1'b0;
				full_q <= 1'b1;
			end
		end else if (full_q && take) begin
			full_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			mag_q <= mag;
			bcd_q <= '0;
			neg_q <= neg;
		end else if (conv_q) begin
			mag_q <= {mag_q[VALUE_WIDTH-2:0], 1'b0};
			bcd_q <= {adj[BCD_W-2:0], mag_q[VALUE_WIDTH-1]};
		end
	end

	assign busy      = conv_q | full_q;
	assign res_valid = full_q;
	assign bcd       = bcd_q;
	assign res_neg   = neg_q;

	a_conv_not_full: assert property (@(posedge clk) disable iff (!arst_n)
		conv_q |-> !full_q)
		else $error("dabble converting while holding a result");

	a_conv_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		conv_q |-> (cnt_q != '0))
		else $error("dabble bit count ran out during conversion");

	a_full_after_conv: assert property (@(posedge clk) disable iff (!arst_n)
		(conv_q && cnt_q == CNT_W'(1) && !start) |=> full_q)
		else $error("dabble result not held after last bit");
endmodule

>>> sv/b2d_emit.sv
`timescale 1ns / 1ps
// leading zero skip and character output of a converted value
module b2d_emit
	import b2d_pkg::*;
#(
	parameter int MAX_DIGITS = 20
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          load_valid,
	input  logic [DIGIT_W*MAX_DIGITS-1:0] bcd,
	input  logic                          neg,
	output logic                          take,
	b2d_out_if.source                     dout
);
	localparam int BCD_W  = DIGIT_W * MAX_DIGITS;
	localparam int LEFT_W = $clog2(MAX_DIGITS + 1);

	emit_state_t        state_q, state_d;
	logic [BCD_W-1:0]   sh_q;
	logic [LEFT_W-1:0]  left_q;
	logic               neg_q;
	logic [DIGIT_W-1:0] top;
	logic               adv;
	logic               shift_en;
	logic               emit_en;
	logic [CHAR_W-1:0]  char_d;
	logic               last_d;
	logic               ov_q;
	logic [CHAR_W-1:0]  char_q;
	logic               last_q;

	assign top = sh_q[BCD_W-1 -: DIGIT_W];
	// output register free or emptied this cycle
	assign adv = !ov_q || dout.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		take     = 1'b0;
		shift_en = 1'b0;
		emit_en  = 1'b0;
		char_d   = CHAR_ZERO;
		last_d   = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (load_valid) begin
					take    = 1'b1;
					state_d = ST_SKIP;
				end
			end
			ST_SKIP: begin
				if (top == '0 && left_q > LEFT_W'(1)) begin
					shift_en = 1'b1;
				end else if (neg_q) begin
					state_d = ST_SIGN;
				end else begin
					state_d = ST_EMIT;
				end
			end
			ST_SIGN: begin
				if (adv) begin
					emit_en = 1'b1;
					char_d  = CHAR_MINUS;
					state_d = ST_EMIT;
				end
			end
			ST_EMIT: begin
				if (adv) begin
					emit_en  = 1'b1;
					shift_en = 1'b1;
					char_d   = CHAR_ZERO + {{(CHAR_W-DIGIT_W){1'b0}}, top};
					last_d   = (left_q == LEFT_W'(1));
					if (left_q == LEFT_W'(1)) begin
						state_d = ST_IDLE;
					end
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			left_q <= '0;
			neg_q  <= 1'b0;
		end else if (take) begin
			left_q <= LEFT_W'(MAX_DIGITS);
			neg_q  <= neg;
		end else if (shift_en) begin
			left_q <= left_q - LEFT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			sh_q <= bcd;
		end else if (shift_en) begin
			sh_q <= {sh_q[BCD_W-DIGIT_W-1:0], {DIGIT_W{1'b0}}};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ov_q <= 1'b0;
		end else if (emit_en) begin
			ov_q <= 1'b1;
		end else if (dout.ready) begin
			ov_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit_en) begin
			char_q <= char_d;
			last_q <= last_d;
		end
	end

	assign dout.valid      = ov_q;
	assign dout.ascii_char = char_q;
	assign dout.last       = last_q;

	a_emit_left: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_EMIT) |-> (left_q != '0))
		else $error("emitting with no digits left");

	a_char_range: assert property (@(posedge clk) disable iff (!arst_n)
		ov_q |-> (char_q == CHAR_MINUS || (char_q >= CHAR_ZERO && char_q <= CHAR_NINE)))
		else $error("character outside sign and digit codes");

	a_skip_top: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SKIP && state_d != ST_SKIP && left_q > LEFT_W'(1)) |-> (top != '0))
		else $error("leading zero left in front of the text");
endmodule

>>> sv/binary_to_decimal_ascii_top.sv
`timescale 1ns / 1ps
// binary word to decimal text converter, top level
//
// din takes a 64-bit word and a signed flag; the low VALUE_WIDTH bits are used
// and read as two's complement when the flag is set. dout returns the decimal
// text one character per word, most significant first, a minus sign ahead of
// negative values, with last high on the final character. Zero gives "0"; a
// magnitude beyond MAX_DIGITS decimal digits keeps its low digits.
// A word passes the bit-serial shift-and-add-3 converter, hands its digits to
// the emitter, then goes through leading zero skip and character output from
// a 4-bit digit shifter, with a minus sign character first when negative.
// din.ready rises again the cycle after the hand-off, so conversion of the next
// word overlaps output of the last one.
// A stalled receiver holds the character in the output register and freezes
// the emitter; din.ready is low while a word converts and while a converted
// result waits for the emitter.
// Reset empties converter and emitter; no text is pending after it.
module binary_to_decimal_ascii_top
	import b2d_pkg::*;
#(
	parameter int VALUE_WIDTH = 64,
	parameter int MAX_DIGITS  = 20
) (
	input  logic      clk,
	input  logic      arst_n,
	b2d_in_if.sink    din,
	b2d_out_if.source dout
);
	localparam int BCD_W = DIGIT_W * MAX_DIGITS;

	logic [VALUE_WIDTH-1:0] v;
	logic                   neg;
	logic [VALUE_WIDTH-1:0] mag;
	logic                   start;
	logic                   busy;
	logic                   res_valid;
	logic [BCD_W-1:0]       bcd;
	logic                   res_neg;
	logic                   take;

	assign v     = din.value[VALUE_WIDTH-1:0];
	assign neg   = din.is_signed && v[VALUE_WIDTH-1];
	// most negative value negates to itself, which is its unsigned magnitude
	assign mag   = neg ? VALUE_WIDTH'(~v + VALUE_WIDTH'(1)) : v;
	assign start = din.valid && din.ready;

	assign din.ready = !busy;

	b2d_dabble #(
		.VALUE_WIDTH (VALUE_WIDTH),
		.MAX_DIGITS  (MAX_DIGITS)
	) u_dabble (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.mag       (mag),
		.neg       (neg),
		.take      (take),
		.busy      (busy),
		.res_valid (res_valid),
		.bcd       (bcd),
		.res_neg   (res_neg)
	);

	b2d_emit #(
		.MAX_DIGITS (MAX_DIGITS)
	) u_emit (
		.clk        (clk),
		.arst_n     (arst_n),
		.load_valid (res_valid),
		.bcd        (bcd),
		.neg        (res_neg),
		.take       (take),
		.dout       (dout)
	);
endmodule

>>> sim/tb_binary_to_decimal_ascii_top.sv
`timescale 1ns / 1ps
// self-checking testbench of the binary to decimal text converter
module tb_binary_to_decimal_ascii_top;
	import b2d_pkg::*;

	localparam int VW         = 64;
	localparam int MD         = 20;
	localparam int HOLD_LEN   = 400;
	localparam int IDLE_LIMIT = 5000;
	localparam int TAIL_LEN   = 100;

	typedef struct packed {
		logic [CHAR_W-1:0] ch;
		logic              last;
	} text_char_t;

	class text_scoreboard;
		text_char_t pending[$];
		int         errors;

		// decimal text of one word, queued in output order
		function void note_word(logic [IN_VALUE_W-1:0] value, logic is_signed);
			logic [VW-1:0] mag;
			logic [3:0]    digs[MD];
			text_char_t    c;
			bit            neg;
			int            nd;
			int            total;
			int            k;
			mag = value[VW-1:0];
			neg = is_signed && mag[VW-1];
			if (neg) begin
				mag = ~mag + 1'b1;
			end
			for (int i = 0; i < MD; i++) begin
				digs[i] = 4'(mag % 64'd10);
				mag     = mag / 64'd10;
			end
			nd = MD;
			while (nd > 1 && digs[nd-1] == 4'd0) begin
				nd--;
			end
			total = nd + (neg ? 1 : 0);
			k     = 0;
			if (neg) begin
				c.ch    = CHAR_MINUS;
				c.last  = (total == 1);
				pending = {pending, c};
				k = 1;
			end
			for (int i = nd - 1; i >= 0; i--) begin
				c.ch    = CHAR_ZERO + digs[i];
				c.last  = (k == total - 1);
				pending = {pending, c};
				k++;
			end
		endfunction

		function void check_char(logic [CHAR_W-1:0] ch, logic last);
			text_char_t exp_c;
			if (pending.size() == 0) begin
				if (errors < 10) begin
					$display("unexpected char %0d last %0b", ch, last);
				end
				errors++;
				return;
			end
			exp_c = pending.pop_front();
			if (exp_c.ch !== ch || exp_c.last !== last) begin
				if (errors < 10) begin
					$display("char mismatch: expected %0d last %0b, got %0d last %0b",
						exp_c.ch, exp_c.last, ch, last);
				end
				errors++;
			end
		endfunction

		function bit empty();
			return pending.size() == 0;
		endfunction
	endclass

	logic clk;
	logic arst_n;

	b2d_in_if  din();
	b2d_out_if dout();

	binary_to_decimal_ascii_top #(
		.VALUE_WIDTH(VW),
		.MAX_DIGITS (MD)
	) u_top (
		.clk   (clk),
		.arst_n(arst_n),
		.din   (din),
		.dout  (dout)
	);

	text_scoreboard sb = new();

	int tx_gap_max = 14;
	int rx_stall_max = 14;
	bit hold_out = 1'b0;

	always #5 clk = ~clk;

	initial begin
		clk           = 1'b0;
		arst_n        = 1'b0;
		din.valid     = 1'b0;
		din.value     = '0;
		din.is_signed = 1'b0;
		dout.ready    = 1'b0;
	end

	function automatic logic [63:0] ten_pow(int p);
		logic [63:0] r;
		r = 64'd1;
		for (int i = 0; i < p; i++) begin
			r = r * 64'd10;
		end
		return r;
	endfunction

	function automatic logic [63:0] rand_word();
		logic [63:0] w;
		case ($urandom_range(0, 5))
			0: begin
				w = {$urandom, $urandom};
			end
			1: begin
				w = 64'($urandom_range(0, 1000));
			end
			2: begin
				w = ten_pow($urandom_range(0, 19)) + 64'($urandom_range(0, 2)) - 64'd1;
			end
			3: begin
				w = 64'($urandom_range(1, 1000));
				w = 64'd0 - w;
			end
			4: begin
				// around the sign boundary and the top of the range
				w = ($urandom_range(0, 1) ? {1'b1, 63'd0} : 64'd0)
					+ 64'($urandom_range(0, 2)) - 64'd1;
			end
			default: begin
				w = {$urandom, $urandom} >> $urandom_range(0, 63);
			end
		endcase
		return w;
	endfunction

	// valid stays high across back-to-back words, dropped only ahead of a gap
	task automatic send_word(input logic [63:0] value, input logic is_signed);
		int gap;
		gap = $urandom_range(0, tx_gap_max);
		if (gap > 0) begin
			din.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		din.valid     <= 1'b1;
		din.value     <= value;
		din.is_signed <= is_signed;
		do @(posedge clk); while (!din.ready);
		sb.note_word(value, is_signed);
	endtask

	task automatic drain();
		din.valid <= 1'b0;
		do @(posedge clk); while (!sb.empty());
	endtask

	task automatic send_random(input int count);
		for (int i = 0; i < count; i++) begin
			send_word(rand_word(), 1'($urandom_range(0, 1)));
		end
	endtask

	// receiver
	initial begin
		int stall;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (hold_out) begin
				dout.ready <= 1'b0;
				repeat (HOLD_LEN) @(posedge clk);
				hold_out = 1'b0;
			end else begin
				stall = $urandom_range(0, rx_stall_max);
				if (stall > 0) begin
					dout.ready <= 1'b0;
					repeat (stall) @(posedge clk);
				end
			end
			dout.ready <= 1'b1;
			do @(posedge clk); while (!dout.valid);
			sb.check_char(dout.ascii_char, dout.last);
		end
	end

	// watchdog on cycles without any word moving
	initial begin
		int idle_cycles;
		idle_cycles = 0;
		while (idle_cycles < IDLE_LIMIT) begin
			@(posedge clk);
			if (!arst_n || (din.valid && din.ready) || (dout.valid && dout.ready)) begin
				idle_cycles = 0;
			end else begin
				idle_cycles++;
			end
		end
		$display("[FAIL] regression broken");
		$finish;
	end

	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// zero, single digits, decade edges, extremes of both readings
		send_word(64'd0, 1'b0);
		send_word(64'd0, 1'b1);
		send_word(64'd1, 1'b0);
		send_word(64'd9, 1'b1);
		send_word(64'd10, 1'b0);
		send_word(64'd99, 1'b1);
		send_word(64'd100, 1'b0);
		send_word({64{1'b1}}, 1'b0);
		send_word({64{1'b1}}, 1'b1);
		send_word({1'b1, 63'd0}, 1'b1);
		send_word({1'b1, 63'd0}, 1'b0);
		send_word({1'b0, {63{1'b1}}}, 1'b1);
		send_word({1'b0, {63{1'b1}}}, 1'b0);
		send_word({1'b1, 62'd0, 1'b1}, 1'b1);
		send_word(ten_pow(19), 1'b0);
		send_word(ten_pow(19) - 64'd1, 1'b0);
		send_word(64'd0 - 64'd10, 1'b1);
		send_word(64'hAAAA_AAAA_AAAA_AAAA, 1'b0);
		send_word(64'h5555_5555_5555_5555, 1'b1);
		drain();

		send_random(120);

		// back to back on both sides
		tx_gap_max   = 0;
		rx_stall_max = 0;
		send_random(60);

		// receiver holds off while words keep coming
		hold_out = 1'b1;
		send_random(40);
		drain();

		tx_gap_max   = 14;
		rx_stall_max = 14;
		send_random(100);
		drain();

		repeat (TAIL_LEN) @(posedge clk);
		if (sb.errors == 0 && sb.empty()) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

endmodule

>>> files.f
sv/b2d_pkg.sv
sv/b2d_in_if.sv
sv/b2d_out_if.sv
sv/b2d_dabble.sv
sv/b2d_emit.sv
sv/binary_to_decimal_ascii_top.sv
sim/tb_binary_to_decimal_ascii_top.sv
